// File: hw/rtl/ptst_pkg.sv
// Package for the periodic timer slot table.
// Holds the slot count, field codes, entry layout and state type.
// No dependencies.
package ptst_pkg;

   localparam int NUM_SLOTS = 8;
   localparam int SLOT_W    = $clog2(NUM_SLOTS);

   localparam logic [1:0] MODE_TICK     = 2'd0;
   localparam logic [1:0] MODE_REGISTER = 2'd1;
   localparam logic [1:0] MODE_REMOVE   = 2'd2;

   localparam logic [1:0] KIND_REGISTERED = 2'd0;
   localparam logic [1:0] KIND_FULL       = 2'd1;
   localparam logic [1:0] KIND_FIRED      = 2'd2;

   typedef struct packed {
      logic [15:0] period;
      logic [15:0] count;
   } entry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_EVAL,
      ST_FLUSH
   } state_type;

endpackage

// File: hw/rtl/periodic_timer_slot_table_top.sv
// Top level of the periodic timer slot table.
// Depends on ptst_pkg.
//
// Usage: one request channel (req_valid/req_ready with req_mode, req_period,
// req_slot) and one response channel (rsp_valid/rsp_ready with rsp_kind,
// rsp_slot_id, rsp_last). A register transaction claims the lowest free slot
// from 1 upward and answers once, with the slot or a table-full status. A
// remove transaction frees a slot in the accepting cycle and gives no
// response. A tick transaction walks slots 1 to NUM_SLOTS-1 through the
// period/count memory one slot at a time (read, then modify and write
// back), and reports each slot that fires, the last one marked by rsp_last.
// A register response passes through the pending register and then the
// output register; a firing is held in the pending register until the next
// firing or the end of the walk pushes it out. Responses leave through an
// output register, so a stalled receiver only holds the walk when a further
// result is ready to be pushed. Reset clears the active bits and control
// state; memory entries are written before they can be observed, so no
// clearing pass is needed.
module periodic_timer_slot_table_top
   import ptst_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_mode,
   input  logic [15:0] req_period,
   input  logic [2:0]  req_slot,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [2:0]  rsp_slot_id,
   output logic        rsp_last
);

   entry_type mem [NUM_SLOTS];

   state_type state_ff, state_in;
   logic [SLOT_W-1:0]    idx_ff, idx_in;
   logic [NUM_SLOTS-1:0] active_ff, active_in;
   entry_type            rd_data_ff;

   logic       pend_valid_ff, pend_valid_in;
   logic [1:0] pend_kind_ff, pend_kind_in;
   logic [2:0] pend_id_ff, pend_id_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [1:0] rsp_kind_ff, rsp_kind_in;
   logic [2:0] rsp_slot_id_ff, rsp_slot_id_in;
   logic       rsp_last_ff, rsp_last_in;

   logic              accept;
   logic              out_free;
   logic              found;
   logic [SLOT_W-1:0] free_idx;
   logic [15:0]       cnt_inc;
   logic              fire;
   logic              eval_go;
   logic              idx_is_last;

   logic              mem_we;
   logic [SLOT_W-1:0] mem_waddr;
   entry_type         mem_wdata;

   logic       push;
   logic [1:0] push_kind;
   logic [2:0] push_id;
   logic       push_last;

   assign req_ready   = (state_ff == ST_IDLE);
   assign accept      = req_valid && req_ready;
   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign cnt_inc     = rd_data_ff.count + 16'd1;
   assign fire        = active_ff[idx_ff] && (cnt_inc >= rd_data_ff.period);
   assign eval_go     = !fire || !pend_valid_ff || out_free;
   assign idx_is_last = (idx_ff == SLOT_W'(NUM_SLOTS - 1));

   always_comb begin
      found    = 1'b0;
      free_idx = '0;
      for (int i = NUM_SLOTS - 1; i >= 1; i--) begin
         if (!active_ff[i]) begin
            found    = 1'b1;
            free_idx = SLOT_W'(i);
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_mode == MODE_TICK) begin
               state_in = ST_READ;
            end else if (accept && req_mode == MODE_REGISTER) begin
               state_in = ST_FLUSH;
            end
         end
         ST_READ: begin
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (eval_go) begin
               state_in = idx_is_last ? ST_FLUSH : ST_READ;
            end
         end
         ST_FLUSH: begin
            if (!pend_valid_ff || out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      idx_in        = idx_ff;
      active_in     = active_ff;
      pend_valid_in = pend_valid_ff;
      pend_kind_in  = pend_kind_ff;
      pend_id_in    = pend_id_ff;
      mem_we        = 1'b0;
      mem_waddr     = idx_ff;
      mem_wdata     = '0;
      push          = 1'b0;
      push_kind     = pend_kind_ff;
      push_id       = pend_id_ff;
      push_last     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            idx_in = SLOT_W'(1);
            if (accept) begin
               unique case (req_mode)
                  MODE_REGISTER: begin
                     pend_valid_in = 1'b1;
                     if (found) begin
                        active_in[free_idx] = 1'b1;
                        mem_we              = 1'b1;
                        mem_waddr           = free_idx;
                        mem_wdata.period    = req_period;
                        mem_wdata.count     = 16'd0;
                        pend_kind_in        = KIND_REGISTERED;
                        pend_id_in          = 3'(free_idx);
                     end else begin
                        pend_kind_in = KIND_FULL;
                        pend_id_in   = 3'd0;
                     end
                  end
                  MODE_REMOVE: begin
                     for (int i = 0; i < NUM_SLOTS; i++) begin
                        if (int'(req_slot) == i) begin
                           active_in[i] = 1'b0;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_READ: begin
         end
         ST_EVAL: begin
            if (eval_go) begin
               mem_we           = 1'b1;
               mem_wdata.period = rd_data_ff.period;
               mem_wdata.count  = fire ? 16'd0 : cnt_inc;
               if (fire) begin
                  push          = pend_valid_ff;
                  pend_valid_in = 1'b1;
                  pend_kind_in  = KIND_FIRED;
                  pend_id_in    = 3'(idx_ff);
               end
               idx_in = idx_ff + SLOT_W'(1);
            end
         end
         ST_FLUSH: begin
            if (pend_valid_ff && out_free) begin
               push          = 1'b1;
               push_last     = 1'b1;
               pend_valid_in = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_kind_in    = rsp_kind_ff;
      rsp_slot_id_in = rsp_slot_id_ff;
      rsp_last_in    = rsp_last_ff;
      if (push) begin
         rsp_valid_in   = 1'b1;
         rsp_kind_in    = push_kind;
         rsp_slot_id_in = push_id;
         rsp_last_in    = push_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         active_ff     <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         active_ff     <= active_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff         <= idx_in;
      pend_kind_ff   <= pend_kind_in;
      pend_id_ff     <= pend_id_in;
      rsp_kind_ff    <= rsp_kind_in;
      rsp_slot_id_ff <= rsp_slot_id_in;
      rsp_last_ff    <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (state_ff == ST_READ) begin
         rd_data_ff <= mem[idx_ff];
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_kind    = rsp_kind_ff;
   assign rsp_slot_id = rsp_slot_id_ff;
   assign rsp_last    = rsp_last_ff;

   // A result must never be left pending once the block is idle again.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !pend_valid_ff)
      else $error("pending result left behind in idle");

   // The reserved slot is never written.
   assert property (@(posedge clock) disable iff (reset)
      mem_we |-> mem_waddr != '0)
      else $error("write to reserved slot");

   // A successful registration never names the reserved slot.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_kind_ff == KIND_REGISTERED |-> rsp_slot_id_ff != 3'd0)
      else $error("registration reported in reserved slot");

   // Evaluation always follows a memory read of the same slot.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EVAL |-> $past(state_ff) == ST_READ || $past(state_ff) == ST_EVAL)
      else $error("evaluation without read");

endmodule

// File: verif/tb_top.sv
// Self-checking testbench for the periodic timer slot table.
// Drives tick, register and remove transactions and predicts every response.
// Depends on ptst_pkg and periodic_timer_slot_table_top.
module tb_top;
   import ptst_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS = 150;
   localparam int HOLD_AT      = 30;
   localparam int HOLD_CYCLES  = 400;
   localparam int IDLE_LIMIT   = 3000;
   localparam int TAIL_CYCLES  = 40;

   typedef struct packed {
      logic [1:0]  mode;
      logic [15:0] period;
      logic [2:0]  slot;
   } timer_req_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [2:0] slot_id;
      logic       last;
   } timer_resp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_mode = MODE_TICK;
   logic [15:0] req_period = '0;
   logic [2:0]  req_slot = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_kind;
   logic [2:0]  rsp_slot_id;
   logic        rsp_last;

   timer_req_type  req_backlog[$];
   timer_resp_type pending_events[$];
   timer_req_type  req_cur;

   logic        slot_on  [NUM_SLOTS];
   logic [15:0] slot_per [NUM_SLOTS];
   logic [15:0] slot_cnt [NUM_SLOTS];

   int items_accepted = 0;
   int resp_count = 0;
   int mismatches = 0;
   int req_gap = 0;
   int rsp_wait = 0;
   int hold_left = 0;
   bit hold_done = 0;
   int idle_cycles = 0;
   int n_ticks = 0, n_regs = 0, n_removes = 0, n_fired = 0, n_full = 0;

   periodic_timer_slot_table_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_mode    (req_mode),
      .req_period  (req_period),
      .req_slot    (req_slot),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_kind    (rsp_kind),
      .rsp_slot_id (rsp_slot_id),
      .rsp_last    (rsp_last)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int draw_gap(input int n);
      return ((n / 24) % 3 == 2) ? 0 : $urandom_range(0, 16);
   endfunction

   task automatic apply_timer_request(input timer_req_type rq);
      timer_resp_type ev;
      logic [2:0]     fired_ids[$];
      bit             placed;
      int             i;
      placed = 1'b0;
      case (rq.mode)
         MODE_REGISTER: begin
            n_regs++;
            for (i = 1; i < NUM_SLOTS; i++) begin
               if (!placed && !slot_on[i]) begin
                  slot_on[i]  = 1'b1;
                  slot_per[i] = rq.period;
                  slot_cnt[i] = '0;
                  ev = '{kind: KIND_REGISTERED, slot_id: 3'(i), last: 1'b1};
                  pending_events.push_back(ev);
                  placed = 1'b1;
               end
            end
            if (!placed) begin
               n_full++;
               ev = '{kind: KIND_FULL, slot_id: 3'd0, last: 1'b1};
               pending_events.push_back(ev);
            end
         end
         MODE_REMOVE: begin
            n_removes++;
            if (int'(rq.slot) < NUM_SLOTS) begin
               slot_on[rq.slot]  = 1'b0;
               slot_per[rq.slot] = '0;
            end
         end
         MODE_TICK: begin
            n_ticks++;
            for (i = 0; i < NUM_SLOTS; i++) slot_cnt[i] = slot_cnt[i] + 16'd1;
            for (i = 1; i < NUM_SLOTS; i++) begin
               if (slot_on[i] && slot_cnt[i] >= slot_per[i]) begin
                  slot_cnt[i] = '0;
                  fired_ids.push_back(3'(i));
               end
            end
            n_fired += fired_ids.size();
            for (i = 0; i < fired_ids.size(); i++) begin
               ev = '{kind: KIND_FIRED, slot_id: fired_ids[i],
                      last: (i == fired_ids.size() - 1)};
               pending_events.push_back(ev);
            end
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_valid && req_ready) begin
            apply_timer_request(req_cur);
            items_accepted++;
            req_gap = draw_gap(items_accepted);
         end
         if (req_valid && !req_ready) begin
         end else if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (req_backlog.size() > 0) begin
            req_cur = req_backlog.pop_front();
            req_valid  <= 1'b1;
            req_mode   <= req_cur.mode;
            req_period <= req_cur.period;
            req_slot   <= req_cur.slot;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // The receiver stops once for a long stretch so that the block backs up.
   always @(posedge clock) begin
      if (reset) begin
         hold_left = 0;
      end else if (hold_left > 0) begin
         hold_left--;
      end else if (!hold_done && items_accepted >= HOLD_AT) begin
         hold_left = HOLD_CYCLES;
         hold_done = 1'b1;
      end
   end

   always @(posedge clock) begin
      timer_resp_type want;
      bit             stray;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_wait = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            resp_count++;
            stray = (pending_events.size() == 0);
            want  = stray ? '0 : pending_events.pop_front();
            if (stray || want.kind !== rsp_kind || want.slot_id !== rsp_slot_id ||
                want.last !== rsp_last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"tb_top: response %0d wrong (stray %0d): ",
                            "expected kind %0d slot %0d last %0d, ",
                            "got kind %0d slot %0d last %0d"},
                           resp_count, stray, want.kind, want.slot_id, want.last,
                           rsp_kind, rsp_slot_id, rsp_last);
            end
            rsp_wait = draw_gap(resp_count);
         end else if (rsp_wait > 0) begin
            rsp_wait--;
         end
         rsp_ready <= (rsp_wait == 0) && (hold_left == 0);
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         idle_cycles = 0;
      end else begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_top: no transaction for %0d cycles", IDLE_LIMIT);
            $display("tb_top: done, errors");
            $finish;
         end
      end
   end

   task automatic queue_req(input logic [1:0] mode, input logic [15:0] period,
                            input logic [2:0] slot);
      timer_req_type rq;
      rq = '{mode: mode, period: period, slot: slot};
      req_backlog.push_back(rq);
   endtask

   initial begin
      int counted;
      int r;
      int total;
      logic [15:0] p;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         slot_on[i]  = 1'b0;
         slot_per[i] = '0;
         slot_cnt[i] = '0;
      end

      // Directed part: empty tick, unused mode, filling the table, removes of
      // slot zero, of an active and of a free slot, and re-registration.
      queue_req(MODE_TICK,     16'hFFFF, 3'd7);
      queue_req(MODE_UNUSED,   16'hFFFF, 3'd7);
      queue_req(MODE_REGISTER, 16'd0,    3'd0);
      queue_req(MODE_REGISTER, 16'd1,    3'd7);
      queue_req(MODE_REGISTER, 16'd2,    3'd0);
      queue_req(MODE_REGISTER, 16'hFFFF, 3'd7);
      queue_req(MODE_REGISTER, 16'd3,    3'd0);
      queue_req(MODE_REGISTER, 16'd4,    3'd5);
      queue_req(MODE_REGISTER, 16'd5,    3'd2);
      queue_req(MODE_REGISTER, 16'd9,    3'd7);
      queue_req(MODE_TICK,     16'h0000, 3'd0);
      queue_req(MODE_TICK,     16'h5A5A, 3'd3);
      queue_req(MODE_TICK,     16'hA5A5, 3'd4);
      queue_req(MODE_REMOVE,   16'hFFFF, 3'd0);
      queue_req(MODE_REMOVE,   16'h0000, 3'd4);
      queue_req(MODE_REMOVE,   16'h1234, 3'd4);
      queue_req(MODE_REGISTER, 16'd7,    3'd1);
      queue_req(MODE_TICK,     16'd0,    3'd6);
      queue_req(MODE_REMOVE,   16'd0,    3'd7);
      queue_req(MODE_UNUSED,   16'd0,    3'd0);
      queue_req(MODE_TICK,     16'd0,    3'd0);
      queue_req(MODE_TICK,     16'hFFFF, 3'd7);
      queue_req(MODE_REMOVE,   16'd0,    3'd1);
      queue_req(MODE_REGISTER, 16'd1,    3'd0);
      queue_req(MODE_TICK,     16'd0,    3'd0);

      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         r = $urandom_range(0, 99);
         p = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 12));
         if (r < 50) queue_req(MODE_TICK, 16'($urandom), 3'($urandom));
         else if (r < 75) queue_req(MODE_REGISTER, p, 3'($urandom));
         else if (r < 95) queue_req(MODE_REMOVE, 16'($urandom), 3'($urandom_range(0, 7)));
         else queue_req(MODE_UNUSED, 16'($urandom), 3'($urandom));
         if (r < 95) counted++;
      end
      total = req_backlog.size();

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (items_accepted < total || pending_events.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("tb_top: %0d requests: %0d ticks, %0d registrations, %0d removals",
               items_accepted, n_ticks, n_regs, n_removes);
      $display("tb_top: %0d responses checked, %0d firings, %0d table-full, %0d mismatches",
               resp_count, n_fired, n_full, mismatches);
      if (mismatches == 0 && pending_events.size() == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule

// File: filelist.f
hw/rtl/ptst_pkg.sv
hw/rtl/periodic_timer_slot_table_top.sv
verif/tb_top.sv
